FILE: sv/utoc_pkg.sv
package utoc_pkg;

    localparam int ELEM_W = 7;

    // controller to datapath
    typedef struct packed {
        logic idle;
        logic accept;
        logic load_write;
        logic walk_start;
        logic deg_read;
        logic scan_check;
        logic edge_check;
        logic step;
        logic row_read;
        logic result_load;
        logic clear_job;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_valid;
        logic last;
        logic n_zero;
        logic idx_last;
        logic ready_one;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/utoc_req_if.sv
interface utoc_req_if;
    logic       valid;
    logic       ready;
    logic [6:0] element;
    logic       starts_sequence;
    logic       last_item;

    modport source (
        output valid,
        output element,
        output starts_sequence,
        output last_item,
        input  ready
    );

    modport sink (
        input  valid,
        input  element,
        input  starts_sequence,
        input  last_item,
        output ready
    );
endinterface

FILE: sv/utoc_rsp_if.sv
interface utoc_rsp_if;
    logic valid;
    logic ready;
    logic is_unique;
    logic input_error;

    modport source (
        output valid,
        output is_unique,
        output input_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  is_unique,
        input  input_error,
        output ready
    );
endinterface

FILE: sv/utoc_ctrl.sv
module utoc_ctrl
    import utoc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_LOAD     = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CHK = 8'b0000_1000,
        S_DECIDE   = 8'b0001_0000,
        S_EDGE_RD  = 8'b0010_0000,
        S_EDGE_CHK = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_write = 1'b1;
                if (sts.last)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = sts.n_zero ? S_FINISH : S_SCAN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.deg_read = 1'b1;
                state_next   = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_check = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                // exactly one ready node: emit it and relax its successors
                if (sts.ready_one)
                begin
                    cmd.row_read = 1'b1;
                    state_next   = S_EDGE_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_EDGE_RD:
            begin
                cmd.deg_read = 1'b1;
                state_next   = S_EDGE_CHK;
            end
            S_EDGE_CHK:
            begin
                cmd.edge_check = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_EDGE_RD;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    cmd.clear_job   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/utoc_dp.sv
module utoc_dp
    import utoc_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [ELEM_W-1:0] cfg_write_data,
    utoc_req_if.sink          request,
    utoc_rsp_if.source        response,
    input  cmd_t              cmd,
    output sts_t              sts
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_NODES + 1);
    localparam int CW = (IW + 1 > ELEM_W) ? IW + 1 : ELEM_W;

    logic [ELEM_W-1:0]    node_count_reg;
    logic [ELEM_W-1:0]    n_eff;
    logic [ELEM_W-1:0]    prev_reg;
    logic                 error_reg;
    logic                 last_reg;
    logic                 edge_en_reg;
    logic [IW-1:0]        from_reg;
    logic [IW-1:0]        to_reg;

    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] row_q;
    logic                 row_vq;

    logic [DW-1:0]        deg_mem [MAX_NODES];
    logic [MAX_NODES-1:0] deg_valid_reg;
    logic [DW-1:0]        deg_q;
    logic                 deg_vq;

    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        cur_reg;
    logic [1:0]           rdy_reg;
    logic [CW-1:0]        emit_reg;

    logic                 out_valid_reg;
    logic                 out_unique_reg;
    logic                 out_error_reg;

    logic                 elem_ok;
    logic                 prev_ok;
    logic [ELEM_W-1:0]    elem_dec;
    logic [ELEM_W-1:0]    prev_dec;
    logic [IW-1:0]        row_addr;
    logic [IW-1:0]        deg_addr;
    logic [DW-1:0]        deg_eff;
    logic                 load_new;
    logic                 adj_we;
    logic [MAX_NODES-1:0] row_wdata;
    logic                 edge_hit;
    logic                 deg_we;
    logic [IW-1:0]        deg_waddr;
    logic [DW-1:0]        deg_wdata;
    logic                 rdy_bump;

    // node count above the storage size saturates
    assign n_eff = (int'(node_count_reg) > MAX_NODES) ? ELEM_W'(MAX_NODES) : node_count_reg;

    assign elem_ok  = (request.element != '0) && (request.element <= n_eff);
    assign prev_ok  = (prev_reg != '0) && (prev_reg <= n_eff);
    assign elem_dec = request.element - ELEM_W'(1);
    assign prev_dec = prev_reg - ELEM_W'(1);

    assign row_addr = cmd.accept ? IW'(prev_dec) : cur_reg;
    assign deg_addr = cmd.accept ? IW'(elem_dec) : idx_reg;

    assign deg_eff   = deg_vq ? deg_q : '0;
    assign load_new  = edge_en_reg && !(row_vq && row_q[to_reg]);
    assign adj_we    = cmd.load_write && load_new;
    assign row_wdata = (row_vq ? row_q : '0)
                     | ({{(MAX_NODES - 1){1'b0}}, 1'b1} << to_reg);

    assign edge_hit  = cmd.edge_check && row_vq && row_q[idx_reg] && (deg_eff != '0);
    assign deg_we    = adj_we || edge_hit;
    assign deg_waddr = cmd.load_write ? to_reg : idx_reg;
    assign deg_wdata = cmd.load_write ? deg_eff + DW'(1) : deg_eff - DW'(1);

    // a node joins the ready set when scanned at zero or relaxed down to zero
    assign rdy_bump = (cmd.scan_check && (deg_eff == '0))
                   || (edge_hit && (deg_eff == DW'(1)));

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[from_reg] <= row_wdata;
        end
        if (cmd.accept || cmd.row_read)
        begin
            row_q  <= adj_mem[row_addr];
            row_vq <= row_valid_reg[row_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (cmd.accept || cmd.deg_read)
        begin
            deg_q  <= deg_mem[deg_addr];
            deg_vq <= deg_valid_reg[deg_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= ELEM_W'(64);
            prev_reg       <= '0;
            error_reg      <= 1'b0;
            last_reg       <= 1'b0;
            edge_en_reg    <= 1'b0;
            from_reg       <= '0;
            to_reg         <= '0;
            row_valid_reg  <= '0;
            deg_valid_reg  <= '0;
            idx_reg        <= '0;
            cur_reg        <= '0;
            rdy_reg        <= '0;
            emit_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_unique_reg <= 1'b0;
            out_error_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                node_count_reg <= cfg_write_data;
            end

            if (cmd.accept)
            begin
                error_reg   <= error_reg || !elem_ok;
                prev_reg    <= request.element;
                last_reg    <= request.last_item;
                edge_en_reg <= elem_ok && !request.starts_sequence && prev_ok;
                from_reg    <= IW'(prev_dec);
                to_reg      <= IW'(elem_dec);
            end

            if (adj_we)
            begin
                row_valid_reg[from_reg] <= 1'b1;
            end
            if (deg_we)
            begin
                deg_valid_reg[deg_waddr] <= 1'b1;
            end

            if (cmd.walk_start)
            begin
                idx_reg  <= '0;
                rdy_reg  <= '0;
                emit_reg <= '0;
            end
            else if (cmd.row_read)
            begin
                idx_reg  <= '0;
                rdy_reg  <= '0;
                emit_reg <= emit_reg + CW'(1);
            end
            else
            begin
                if (cmd.step)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (rdy_bump)
                begin
                    cur_reg <= idx_reg;
                    if (rdy_reg != 2'd2)
                    begin
                        rdy_reg <= rdy_reg + 2'd1;
                    end
                end
            end

            if (cmd.result_load)
            begin
                out_valid_reg  <= 1'b1;
                out_unique_reg <= !error_reg && (emit_reg == CW'(n_eff));
                out_error_reg  <= error_reg;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.clear_job)
            begin
                prev_reg      <= '0;
                error_reg     <= 1'b0;
                row_valid_reg <= '0;
                deg_valid_reg <= '0;
            end
        end
    end

    assign request.ready        = cmd.idle;
    assign response.valid       = out_valid_reg;
    assign response.is_unique   = out_unique_reg;
    assign response.input_error = out_error_reg;

    assign sts.req_valid = request.valid;
    assign sts.last      = last_reg;
    assign sts.n_zero    = (n_eff == '0);
    assign sts.idx_last  = (CW'(idx_reg) + CW'(1)) == CW'(n_eff);
    assign sts.ready_one = (rdy_reg == 2'd1);
    assign sts.out_free  = !out_valid_reg || response.ready;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deg_read |-> (CW'(idx_reg) < CW'(n_eff)))
        else $error("walk index past node count");

    a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_read |=> (emit_reg <= CW'(n_eff)))
        else $error("more nodes emitted than exist");

    a_single_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_read |-> (rdy_reg == 2'd1))
        else $error("node emitted without a single ready candidate");

    a_job_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_job |=> (row_valid_reg == '0 && deg_valid_reg == '0 && !error_reg
                           && prev_reg == '0))
        else $error("job state not cleared after result");
`endif

endmodule

FILE: sv/unique_topological_order_check.sv
// unique topological order check
// request channel: one sequence element per request (element, starts_sequence,
// last_item). neighboring elements of a sequence record an edge prev -> element
// in an adjacency matrix; a new edge bumps the successor's in-degree.
// response channel: one result (is_unique, input_error) per job, issued after
// the request that carries last_item.
// configuration: cfg_write_en/cfg_write_data set node_count (reset 64); write
// only while no job is being walked.
// requests: each accepted request reads the row and degree memories and then
// writes them in the load state; no new request is taken until that write is done.
// after the request with last_item, the walk runs: a scan pass over all nodes,
// then per emitted node a pass relaxing its successors (none when the node count is 0);
// each walk pass visits every node over the single degree memory port.
// reset clears the node count to 64 and all job state; valid bits per row and
// per degree entry clear the memories at once, also after each result.
// the result sits in an output register; while the receiver stalls, requests
// of the next job are still taken, and a further result waits until it drains.
module unique_topological_order_check
    import utoc_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [ELEM_W-1:0] cfg_write_data,
    utoc_req_if.sink          request,
    utoc_rsp_if.source        response
);

    cmd_t cmd;
    sts_t sts;

    utoc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    utoc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .request        (request),
        .response       (response),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
